// File: sv/plst_pkg.sv
package plst_pkg;

  localparam int DEPTH = 16;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 32;
  localparam int PW    = 8;
  localparam int LW    = 5;
  localparam int XW    = 9;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_FIND      = 3'd6,
    CMD_DUMP      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic exec;
    logic dump_start;
    logic dump_load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic dump_last;
  } dp_stat_t;

endpackage

// File: sv/plst_if.sv
interface plst_req_if (input logic clk);
  import plst_pkg::*;
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic signed [VW-1:0] value;
  logic [PW-1:0]       position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface plst_rsp_if (input logic clk);
  import plst_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic                found;
  logic signed [VW-1:0] element;
  logic                last;
  logic [LW-1:0]       length;

  modport source (output valid, status, found, element, last, length, input ready);
  modport sink   (input valid, status, found, element, last, length, output ready);
endinterface

// File: sv/plst_ctrl.sv
module plst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  plst_pkg::cmd_t     req_command,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output plst_pkg::dp_cmd_t  dp_cmd,
  input  plst_pkg::dp_stat_t dp_stat
);
  import plst_pkg::*;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   free;
  logic   load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    free       = !rsp_valid || rsp_ready;
    state_next = state;
    req_ready  = 1'b0;
    dp_cmd     = '0;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = free;
        if (req_valid && free) begin
          if (req_command == CMD_DUMP && !dp_stat.empty) begin
            dp_cmd.dump_start = 1'b1;
            state_next        = S_DUMP;
          end else begin
            dp_cmd.exec = 1'b1;
            load        = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (free) begin
          dp_cmd.dump_load = 1'b1;
          load             = 1'b1;
          if (dp_stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    rsp_valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid);
  end

endmodule

// File: sv/plst_dp.sv
module plst_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  plst_pkg::cmd_t               req_command,
  input  logic signed [plst_pkg::VW-1:0] req_value,
  input  logic [plst_pkg::PW-1:0]      req_position,
  output plst_pkg::status_t            rsp_status,
  output logic                         rsp_found,
  output logic signed [plst_pkg::VW-1:0] rsp_element,
  output logic                         rsp_last,
  output logic [plst_pkg::LW-1:0]      rsp_length,
  input  plst_pkg::dp_cmd_t            dp_cmd,
  output plst_pkg::dp_stat_t           dp_stat
);
  import plst_pkg::*;

  logic signed [VW-1:0] cells [DEPTH];
  logic signed [VW-1:0] cells_next [DEPTH];
  logic signed [VW-1:0] up [DEPTH];
  logic signed [VW-1:0] dn [DEPTH];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [IW-1:0]        dump_idx;

  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] idx;
  logic          do_ins;
  logic          do_del;
  logic          hit;
  status_t       st;

  always_comb begin
    cnt_x  = XW'(count);
    pos_x  = XW'(req_position);
    idx    = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    st     = ST_OK;
    unique case (req_command)
      CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
        priority if (req_command == CMD_INS_AT &&
                     (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
          st = ST_BADPOS;
        end else if (count == CW'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx = (req_command == CMD_INS_FRONT) ? '0 :
                (req_command == CMD_INS_END)   ? cnt_x : pos_x - XW'(1);
        end
      end
      CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
        priority if (count == '0) begin
          st = ST_EMPTY;
        end else if (req_command == CMD_DEL_AT &&
                     (pos_x == '0 || pos_x > cnt_x)) begin
          st = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          idx = (req_command == CMD_DEL_FRONT) ? '0 :
                (req_command == CMD_DEL_END)   ? cnt_x - XW'(1) : pos_x - XW'(1);
        end
      end
      CMD_FIND: st = ST_OK;
      CMD_DUMP: st = ST_EMPTY;
      default:  st = ST_OK;
    endcase
  end

  // shifted copies for insert and delete
  always_comb begin
    up[0] = req_value;
    for (int i = 1; i < DEPTH; i++) begin
      up[i] = cells[i-1];
    end
    dn[DEPTH-1] = cells[DEPTH-1];
    for (int i = 0; i < DEPTH - 1; i++) begin
      dn[i] = cells[i+1];
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (do_ins) begin
        if (XW'(i) == idx) begin
          cells_next[i] = req_value;
        end else if (XW'(i) > idx) begin
          cells_next[i] = up[i];
        end
      end else if (do_del && XW'(i) >= idx) begin
        cells_next[i] = dn[i];
      end
      if (XW'(i) < cnt_x && cells[i] == req_value) begin
        hit = 1'b1;
      end
    end
    count_next = do_ins ? count + CW'(1) : (do_del ? count - CW'(1) : count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.dump_start) begin
      dump_idx <= '0;
    end else if (dp_cmd.dump_load) begin
      dump_idx <= dump_idx + IW'(1);
    end
  end

  assign dp_stat.empty     = (count == '0);
  assign dp_stat.dump_last = (CW'(dump_idx) + CW'(1) == count);

  // result register
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      rsp_status  <= st;
      rsp_found   <= (req_command == CMD_FIND) ? hit : 1'b0;
      rsp_element <= '0;
      rsp_last    <= 1'b1;
      rsp_length  <= LW'(count_next);
    end else if (dp_cmd.dump_load) begin
      rsp_status  <= ST_OK;
      rsp_found   <= 1'b0;
      rsp_element <= cells[dump_idx];
      rsp_last    <= dp_stat.dump_last;
      rsp_length  <= LW'(count);
    end
  end

endmodule

// File: sv/positional_list_store_top.sv
// Ordered list of up to DEPTH signed 32-bit values held in a row of shift
// cells. Insert, delete and find each give one beat; a dump first clears
// its read index and then gives one beat per element, in list order, each
// once the output register is free, with last set on the final one (an
// empty list dumps as a single empty beat, like the other commands).
// Results go through one output register, so a new request is taken as
// soon as that register is free; req.ready stays low while a dump streams.
module positional_list_store_top (
  input logic       clk,
  input logic       rst,
  plst_req_if.sink  req,
  plst_rsp_if.source rsp
);
  import plst_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  plst_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat)
  );

  plst_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_command  (req.command),
    .req_value    (req.value),
    .req_position (req.position),
    .rsp_status   (rsp.status),
    .rsp_found    (rsp.found),
    .rsp_element  (rsp.element),
    .rsp_last     (rsp.last),
    .rsp_length   (rsp.length),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat)
  );

endmodule
